@@ hw/rtl/rqds_pkg.sv @@
// Package for the ready queue dispatch selector.
// Holds the transaction structs, register and mode codes, and cell bundles.
// No dependencies.
package rqds_pkg;

  localparam int NUM_TASKS  = 4;
  localparam int ID_W       = 2;
  localparam int DEADLINE_W = 32;
  localparam int PERIOD_W   = 16;
  localparam int KEY_W      = 32;
  localparam int QCOUNT_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 3'd4;

  typedef logic [NUM_TASKS-1:0][PERIOD_W-1:0] period_arr_t;

  localparam period_arr_t PERIOD_RESET = {16'd6000, 16'd4000, 16'd2000, 16'd1000};

  typedef struct packed {
    logic                  operation;
    logic [ID_W-1:0]       task_id;
    logic [DEADLINE_W-1:0] task_deadline;
    logic                  cpu_busy;
  } req_t;

  typedef struct packed {
    logic                dispatched;
    logic [ID_W-1:0]     dispatched_task;
    logic [QCOUNT_W-1:0] queue_count;
    logic                overflow;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [DEADLINE_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } scan_t;

  typedef struct packed {
    logic        cmp_en;
    logic        edf_sel;
    period_arr_t periods;
  } sel_cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

@@ hw/rtl/rqds_cell.sv @@
// One queue slot: holds a task id and deadline, shifts left on removal,
// and passes the best-so-far comparison token to its right neighbour.
// Depends on rqds_pkg.
module rqds_cell #(
  parameter int POS_W = 2,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rqds_pkg::entry_t    wr_entry,
  input  logic                shift_en,
  input  logic [POS_W-1:0]    shift_sel,
  input  rqds_pkg::entry_t    right_entry,
  input  logic                occupied,
  input  rqds_pkg::sel_cfg_t  cfg,
  input  rqds_pkg::scan_t     scan_in,
  input  logic [POS_W-1:0]    scan_in_pos,
  output rqds_pkg::scan_t     scan_out,
  output logic [POS_W-1:0]    scan_out_pos,
  output rqds_pkg::entry_t    entry
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [rqds_pkg::KEY_W-1:0] key;
  logic                       take;

  assign key  = cfg.edf_sel ? entry.deadline
                            : rqds_pkg::KEY_W'(cfg.periods[entry.id]);
  assign take = scan_in.valid && occupied &&
                (!scan_in.found || (cfg.cmp_en && (key < scan_in.key)));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
      scan_out.found <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
      scan_out.found <= scan_in.found || take;
    end
    if (take) begin
      scan_out.key <= key;
      scan_out.id  <= entry.id;
      scan_out_pos <= MY_POS;
    end else begin
      scan_out.key <= scan_in.key;
      scan_out.id  <= scan_in.id;
      scan_out_pos <= scan_in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end else if (shift_en && (MY_POS >= shift_sel)) begin
      entry <= right_entry;
    end
  end

endmodule

@@ hw/rtl/rqds_res_buf.sv @@
// Two-slot result buffer: output register plus skid slot, so an item can be
// taken while an earlier result waits on a stalled receiver.
// Depends on rqds_pkg.
module rqds_res_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rqds_pkg::res_t push_item,
  output logic           skid_full,
  output logic           res_valid,
  input  logic           res_stall,
  output rqds_pkg::res_t res
);

  rqds_pkg::res_t skid;
  logic           pop;
  logic           head_free;

  assign pop       = res_valid && !res_stall;
  assign head_free = !res_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (head_free) begin
      if (skid_full) begin
        res_valid <= 1'b1;
        skid_full <= push;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_full) begin
        res <= skid;
        if (push) begin
          skid <= push_item;
        end
      end else if (push) begin
        res <= push_item;
      end
    end else if (push) begin
      skid <= push_item;
    end
  end

endmodule

@@ hw/rtl/ready_queue_dispatch_selector.sv @@
// Ready queue dispatch selector: top level with control sequencer, config
// registers, row of queue cells and result buffer.
// Depends on rqds_pkg, rqds_cell and rqds_res_buf.
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+-----------------------------
//  req     | req_valid, req_stall, req     | req_valid && !req_stall
//  res     | res_valid, res_stall, res     | res_valid && !res_stall
//  cfg     | cfg_we, cfg_index, cfg_data   | cfg_we
//
// Enqueues and dispatches that release nothing complete without a scan.
// A releasing dispatch runs a scan: the comparison token walks the cell
// row one cell per cycle, then the row shifts left.
// Synchronous reset empties the queue and loads the default periods.
// A stalled result is held in a skid slot; req stalls only while a scan runs
// or the skid slot is occupied.
module ready_queue_dispatch_selector #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  rqds_pkg::req_t                     req,
  output logic                               res_valid,
  input  logic                               res_stall,
  output rqds_pkg::res_t                     res,
  input  logic                               cfg_we,
  input  logic [rqds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rqds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int POS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rqds_pkg::state_t      state;
  rqds_pkg::state_t      state_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [rqds_pkg::MODE_W-1:0] mode;
  rqds_pkg::period_arr_t periods;
  rqds_pkg::sel_cfg_t    sel_cfg;

  logic                  req_accept;
  logic                  full;
  logic                  disp_go;
  logic                  wr_go;
  logic                  start;
  logic                  shift_en;
  logic                  push;
  rqds_pkg::res_t        push_item;
  logic                  skid_full;
  rqds_pkg::entry_t      wr_entry;

  rqds_pkg::scan_t       scan_chain [QUEUE_DEPTH+1];
  logic [POS_W-1:0]      pos_chain  [QUEUE_DEPTH+1];
  rqds_pkg::entry_t      entries    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] scan_valid_vec;
  rqds_pkg::scan_t       scan_last;
  logic [POS_W-1:0]      sel_pos;

  assign req_stall  = (state != rqds_pkg::ST_IDLE) || skid_full;
  assign req_accept = req_valid && !req_stall;
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign disp_go    = (req.operation == rqds_pkg::OP_DISPATCH) &&
                      (count != '0) && !req.cpu_busy;

  assign wr_entry.id       = req.task_id;
  assign wr_entry.deadline = req.task_deadline;

  assign sel_cfg.cmp_en  = (mode == rqds_pkg::MODE_EDF) || (mode == rqds_pkg::MODE_RM);
  assign sel_cfg.edf_sel = (mode == rqds_pkg::MODE_EDF);
  assign sel_cfg.periods = periods;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= rqds_pkg::MODE_FIFO;
      periods <= rqds_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rqds_pkg::REG_MODE:    mode       <= cfg_data[rqds_pkg::MODE_W-1:0];
        rqds_pkg::REG_PERIOD0: periods[0] <= cfg_data;
        rqds_pkg::REG_PERIOD1: periods[1] <= cfg_data;
        rqds_pkg::REG_PERIOD2: periods[2] <= cfg_data;
        rqds_pkg::REG_PERIOD3: periods[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Seed the token at the head of the row
  assign scan_chain[0].valid = start;
  assign scan_chain[0].found = 1'b0;
  assign scan_chain[0].key   = '0;
  assign scan_chain[0].id    = '0;
  assign pos_chain[0]        = '0;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      rqds_pkg::entry_t right;
      logic             occ;
      logic             wr_here;

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right = entries[i];
      end else begin : g_body
        assign right = entries[i+1];
      end

      assign occ     = (count > CNT_W'(i));
      assign wr_here = wr_go && (count == CNT_W'(i));
      assign scan_valid_vec[i] = scan_chain[i+1].valid;

      rqds_cell #(
        .POS_W (POS_W),
        .IDX   (i)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .wr_en        (wr_here),
        .wr_entry     (wr_entry),
        .shift_en     (shift_en),
        .shift_sel    (sel_pos),
        .right_entry  (right),
        .occupied     (occ),
        .cfg          (sel_cfg),
        .scan_in      (scan_chain[i]),
        .scan_in_pos  (pos_chain[i]),
        .scan_out     (scan_chain[i+1]),
        .scan_out_pos (pos_chain[i+1]),
        .entry        (entries[i])
      );
    end
  endgenerate

  assign scan_last = scan_chain[QUEUE_DEPTH];
  assign sel_pos   = pos_chain[QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqds_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rqds_pkg::ST_IDLE: begin
        if (req_accept && disp_go) begin
          state_next = rqds_pkg::ST_SCAN;
        end
      end
      rqds_pkg::ST_SCAN: begin
        if (scan_last.valid) begin
          state_next = rqds_pkg::ST_IDLE;
        end
      end
      default: state_next = rqds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wr_go      = 1'b0;
    start      = 1'b0;
    shift_en   = 1'b0;
    push       = 1'b0;
    push_item  = '0;
    count_next = count;
    unique case (state)
      rqds_pkg::ST_IDLE: begin
        if (req_accept) begin
          if (req.operation == rqds_pkg::OP_ENQUEUE) begin
            push = 1'b1;
            if (full) begin
              push_item.overflow = 1'b1;
            end else begin
              wr_go      = 1'b1;
              count_next = count + CNT_W'(1);
            end
            push_item.queue_count = rqds_pkg::QCOUNT_W'(count_next);
          end else if (disp_go) begin
            start = 1'b1;
          end else begin
            push                  = 1'b1;
            push_item.queue_count = rqds_pkg::QCOUNT_W'(count);
          end
        end
      end
      rqds_pkg::ST_SCAN: begin
        if (scan_last.valid) begin
          shift_en                  = 1'b1;
          push                      = 1'b1;
          count_next                = count - CNT_W'(1);
          push_item.dispatched      = 1'b1;
          push_item.dispatched_task = scan_last.id;
          push_item.queue_count     = rqds_pkg::QCOUNT_W'(count_next);
        end
      end
      default: ;
    endcase
  end

  rqds_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .skid_full (skid_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(scan_valid_vec))
    else $error("more than one comparison token in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_last.valid |-> (state == rqds_pkg::ST_SCAN))
    else $error("token left the row outside a scan");

  a_release_decrements: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.dispatched) |=> (count == $past(count) - CNT_W'(1)))
    else $error("release did not drop the count");

  a_enqueue_increments: assert property (@(posedge clk) disable iff (rst)
    (req_accept && (req.operation == rqds_pkg::OP_ENQUEUE) && !full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue did not raise the count");

endmodule
